// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked concurrent assertions with an asynchronous reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define AST_HOLDS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// The expression must never be true outside reset.
`define AST_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ----- rtl/bcio_pkg.sv -----
// ----------------------------------------------------------------------------
// Board control I/O package
// Request and response types, register offsets and fixed constants.
// ----------------------------------------------------------------------------
package bcio_pkg;

	typedef enum logic [1:0] {
		REQ_READ  = 2'd0,
		REQ_WRITE = 2'd1,
		REQ_TICK  = 2'd2,
		REQ_NOP   = 2'd3
	} req_kind_t;

	typedef enum logic [1:0] {
		CFG_HAS_DBG    = 2'd0,
		CFG_HAS_SWITCH = 2'd1,
		CFG_LED_COUNT  = 2'd2,
		CFG_CLOCK_HZ   = 2'd3
	} cfg_idx_t;

	localparam logic [11:0] OFS_LED      = 12'h000;
	localparam logic [11:0] OFS_DBGCTRL  = 12'h004;
	localparam logic [11:0] OFS_BUTTON   = 12'h008;
	localparam logic [11:0] OFS_CLK1HZ   = 12'h010;
	localparam logic [11:0] OFS_CLK100HZ = 12'h014;
	localparam logic [11:0] OFS_COUNTER  = 12'h018;
	localparam logic [11:0] OFS_PRESCALE = 12'h01c;
	localparam logic [11:0] OFS_PSCNTR   = 12'h020;
	localparam logic [11:0] OFS_SWITCH   = 12'h028;
	localparam logic [11:0] OFS_MISC     = 12'h04c;

	localparam logic [31:0] CLK_MIN         = 32'd100;
	localparam logic [31:0] CLK_HZ_RESET    = 32'd20000000;
	localparam logic [5:0]  LED_COUNT_RESET = 6'd2;
	localparam logic [6:0]  SEC_STEP        = 7'd1;
	localparam logic [6:0]  HUN_STEP        = 7'd100;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [11:0] reg_offset;
		logic [31:0] write_data;
	} req_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        ofs_err;
		logic [31:0] led_drive;
	} rsp_t;

endpackage

// ----- rtl/bcio_ifs.sv -----
// ----------------------------------------------------------------------------
// Board control I/O channels
// Valid/ready channels for requests and responses.
// ----------------------------------------------------------------------------
interface bcio_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [11:0] reg_offset;
	logic [31:0] write_data;

	modport source (output valid, output req_type, output reg_offset, output write_data,
		input ready);
	modport sink (input valid, input req_type, input reg_offset, input write_data,
		output ready);
endinterface

interface bcio_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] read_data;
	logic        ofs_err;
	logic [31:0] led_drive;

	modport source (output valid, output read_data, output ofs_err, output led_drive,
		input ready);
	modport sink (input valid, input read_data, input ofs_err, input led_drive,
		output ready);
endinterface

// ----- rtl/bcio_slowcnt.sv -----
// ----------------------------------------------------------------------------
// Board control I/O slow counter
// Phase accumulator that advances a loadable counter at step/clk_eff counts per tick.
// ----------------------------------------------------------------------------
module bcio_slowcnt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        tick,
	input  logic        load,
	input  logic [31:0] load_data,
	input  logic [6:0]  step,
	input  logic [31:0] clk_eff,
	output logic [31:0] count
);

	logic [32:0] phase_q;
	logic [31:0] count_q;
	logic [32:0] phase_sum;
	logic        wrap;

	assign phase_sum = phase_q + 33'(step);
	assign wrap      = phase_sum >= 33'(clk_eff);
	assign count     = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			count_q <= '0;
		end else if (load) begin
			phase_q <= '0;
			count_q <= load_data;
		end else if (tick) begin
			if (wrap) begin
				phase_q <= phase_sum - 33'(clk_eff);
				count_q <= count_q + 32'd1;
			end else begin
				phase_q <= phase_sum;
			end
		end
	end

endmodule

// ----- rtl/bcio_core.sv -----
// ----------------------------------------------------------------------------
// Board control I/O register core
// Configuration, register file, prescaled counter and access decode.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bcio_core #(
	parameter int MAX_LEDS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_wdata,
	input  logic                en,
	input  bcio_pkg::req_t      req,
	output bcio_pkg::rsp_t      rsp
);

	logic                has_dbg_q;
	logic                has_sw_q;
	logic [5:0]          led_count_q;
	logic [31:0]         clock_hz_q;

	logic [MAX_LEDS-1:0] led_q;
	logic [31:0]         dbg_q;
	logic [31:0]         misc_q;
	logic [31:0]         reload_q;
	logic [31:0]         pscnt_q;
	logic [31:0]         evt_q;

	logic [31:0]         sec_count;
	logic [31:0]         hun_count;
	logic [31:0]         clk_eff;
	logic [MAX_LEDS-1:0] led_mask;
	logic [MAX_LEDS-1:0] led_next;

	logic                is_rd;
	logic                is_wr;
	logic                is_tick;
	logic [31:0]         rd;
	logic                bad;
	logic                wr_led;
	logic                wr_dbg;
	logic                wr_sec;
	logic                wr_hun;
	logic                wr_evt;
	logic                wr_reload;
	logic                wr_pscnt;
	logic                wr_misc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			has_dbg_q   <= 1'b0;
			has_sw_q    <= 1'b0;
			led_count_q <= bcio_pkg::LED_COUNT_RESET;
			clock_hz_q  <= bcio_pkg::CLK_HZ_RESET;
		end else if (cfg_we) begin
			case (bcio_pkg::cfg_idx_t'(cfg_index))
				bcio_pkg::CFG_HAS_DBG:    has_dbg_q   <= cfg_wdata[0];
				bcio_pkg::CFG_HAS_SWITCH: has_sw_q    <= cfg_wdata[0];
				bcio_pkg::CFG_LED_COUNT:  led_count_q <= cfg_wdata[5:0];
				bcio_pkg::CFG_CLOCK_HZ:   clock_hz_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign is_rd   = req.req_type == bcio_pkg::REQ_READ;
	assign is_wr   = req.req_type == bcio_pkg::REQ_WRITE;
	assign is_tick = req.req_type == bcio_pkg::REQ_TICK;
	assign clk_eff = (clock_hz_q < bcio_pkg::CLK_MIN) ? bcio_pkg::CLK_MIN : clock_hz_q;

	always_comb begin
		for (int i = 0; i < MAX_LEDS; i++) begin
			led_mask[i] = led_count_q > 6'(i);
		end
	end

	always_comb begin
		rd  = '0;
		bad = 1'b0;
		case (req.reg_offset)
			bcio_pkg::OFS_LED:      rd = 32'(led_q);
			bcio_pkg::OFS_DBGCTRL: begin
				rd  = has_dbg_q ? dbg_q : '0;
				bad = !has_dbg_q;
			end
			bcio_pkg::OFS_BUTTON:   bad = is_wr;
			bcio_pkg::OFS_CLK1HZ:   rd = sec_count;
			bcio_pkg::OFS_CLK100HZ: rd = hun_count;
			bcio_pkg::OFS_COUNTER:  rd = evt_q;
			bcio_pkg::OFS_PRESCALE: rd = reload_q;
			bcio_pkg::OFS_PSCNTR:   rd = pscnt_q;
			bcio_pkg::OFS_SWITCH:   bad = is_wr || !has_sw_q;
			bcio_pkg::OFS_MISC:     rd = misc_q;
			default:                bad = 1'b1;
		endcase
	end

	assign wr_led    = is_wr && req.reg_offset == bcio_pkg::OFS_LED && led_count_q != '0;
	assign wr_dbg    = is_wr && req.reg_offset == bcio_pkg::OFS_DBGCTRL && has_dbg_q;
	assign wr_sec    = is_wr && req.reg_offset == bcio_pkg::OFS_CLK1HZ;
	assign wr_hun    = is_wr && req.reg_offset == bcio_pkg::OFS_CLK100HZ;
	assign wr_evt    = is_wr && req.reg_offset == bcio_pkg::OFS_COUNTER;
	assign wr_reload = is_wr && req.reg_offset == bcio_pkg::OFS_PRESCALE;
	assign wr_pscnt  = is_wr && req.reg_offset == bcio_pkg::OFS_PSCNTR;
	assign wr_misc   = is_wr && req.reg_offset == bcio_pkg::OFS_MISC;

	assign led_next = wr_led ? (req.write_data[MAX_LEDS-1:0] & led_mask) : led_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_q    <= '0;
			dbg_q    <= '0;
			misc_q   <= '0;
			reload_q <= '0;
			pscnt_q  <= '0;
			evt_q    <= '0;
		end else if (en) begin
			led_q <= led_next;
			if (wr_dbg) begin
				dbg_q <= req.write_data;
			end
			if (wr_misc) begin
				misc_q <= req.write_data;
			end
			if (wr_reload) begin
				reload_q <= req.write_data;
			end
			if (wr_pscnt) begin
				pscnt_q <= req.write_data;
			end else if (is_tick) begin
				pscnt_q <= (pscnt_q == '0) ? reload_q : pscnt_q - 32'd1;
			end
			if (wr_evt) begin
				evt_q <= req.write_data;
			end else if (is_tick && pscnt_q == '0) begin
				evt_q <= evt_q + 32'd1;
			end
		end
	end

	bcio_slowcnt u_sec (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick      (en && is_tick),
		.load      (en && wr_sec),
		.load_data (req.write_data),
		.step      (bcio_pkg::SEC_STEP),
		.clk_eff   (clk_eff),
		.count     (sec_count)
	);

	bcio_slowcnt u_hun (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick      (en && is_tick),
		.load      (en && wr_hun),
		.load_data (req.write_data),
		.step      (bcio_pkg::HUN_STEP),
		.clk_eff   (clk_eff),
		.count     (hun_count)
	);

	assign rsp.read_data = is_rd ? rd : '0;
	assign rsp.ofs_err   = (is_rd || is_wr) && bad;
	assign rsp.led_drive = 32'(led_next);

	`AST_HOLDS(a_ps_dec, clk, arst_n, en && is_tick && pscnt_q != '0 |=> pscnt_q == $past(pscnt_q) - 32'd1, "Prescale counter did not decrement on a tick.")
	`AST_HOLDS(a_evt_inc, clk, arst_n, en && is_tick && pscnt_q == '0 |=> evt_q == $past(evt_q) + 32'd1, "Event counter did not advance on a prescale wrap.")
	`AST_HOLDS(a_tick_keep, clk, arst_n, en && is_tick |=> $stable(led_q) && $stable(misc_q), "A tick changed a bus register.")

endmodule

// ----- rtl/board_control_io_with_prescaled_counter_core.sv -----
// ----------------------------------------------------------------------------
// Board control I/O with prescaled counter
// Top level: request register, register core and response register.
// ----------------------------------------------------------------------------
// Every request on the req channel is a bus read, a bus write, one tick of
// the prescale clock or a no-op, and produces exactly one response on the
// rsp channel carrying read data, an offset error flag and the current LED
// bits. A request transfer lands in the request register; when the response
// register is free or being taken, the core decodes it, updates its
// registers and loads the response register. Throughput is one request per
// cycle while the receiver does not stall. When the receiver stalls, the
// response register holds its transfer and the request register holds one
// more request; req.ready drops only when both are full. Configuration is
// written on cfg_we/cfg_index/cfg_wdata; the user must write it only while
// the block is idle, which the block itself does not enforce. Reset clears
// every counter and bus register, sets the LED count to two and the clock
// rate to 20000000 ticks per second, and leaves both channels empty.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module board_control_io_with_prescaled_counter_core #(
	parameter int MAX_LEDS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_wdata,
	bcio_req_if.sink    req,
	bcio_rsp_if.source  rsp
);

	logic            valid_s1;
	bcio_pkg::req_t  req_s1;
	logic            valid_s2;
	bcio_pkg::rsp_t  rsp_s2;
	bcio_pkg::rsp_t  core_rsp;
	logic            adv;

	assign adv       = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_s1.req_type   <= req.req_type;
			req_s1.reg_offset <= req.reg_offset;
			req_s1.write_data <= req.write_data;
		end
	end

	bcio_core #(
		.MAX_LEDS (MAX_LEDS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.en        (adv),
		.req       (req_s1),
		.rsp       (core_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || rsp.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_s2 <= core_rsp;
		end
	end

	assign rsp.valid     = valid_s2;
	assign rsp.read_data = rsp_s2.read_data;
	assign rsp.ofs_err   = rsp_s2.ofs_err;
	assign rsp.led_drive = rsp_s2.led_drive;

	`AST_HOLDS(a_adv_fills, clk, arst_n, adv |=> valid_s2, "A processed request left no response.")
	`AST_HOLDS(a_stall_hold, clk, arst_n, valid_s2 && !rsp.ready |=> valid_s2 && $stable(rsp_s2), "A stalled response was lost or changed.")
	`AST_HOLDS(a_stall_keep, clk, arst_n, req.valid && req.ready && valid_s2 && !rsp.ready |=> valid_s1, "A request taken under stall was lost.")

endmodule

// ----- tb/tb_board_control_io_with_prescaled_counter_core.sv -----
// ----------------------------------------------------------------------------
// Board control I/O testbench
// Sends bus reads, bus writes, prescale ticks and stray requests through the
// request channel under several register settings. A built-in predictor
// tracks the LED, debug, misc, prescale, counter and slow clock registers and
// checks every response transfer in order. Both channels idle at random, and
// the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_board_control_io_with_prescaled_counter_core;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_OFF_CYCLES = 48;
	localparam logic [15:0] STALL_PATTERN = 16'b1011_0111_0110_1101;
	localparam logic [11:0] REG_OFFSETS [0:9] = '{bcio_pkg::OFS_LED, bcio_pkg::OFS_DBGCTRL,
		bcio_pkg::OFS_BUTTON, bcio_pkg::OFS_CLK1HZ, bcio_pkg::OFS_CLK100HZ,
		bcio_pkg::OFS_COUNTER, bcio_pkg::OFS_PRESCALE, bcio_pkg::OFS_PSCNTR,
		bcio_pkg::OFS_SWITCH, bcio_pkg::OFS_MISC};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_wdata;

	bcio_req_if req_ch ();
	bcio_rsp_if rsp_ch ();

	board_control_io_with_prescaled_counter_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	// Predicted register state and settings.
	logic        dbg_on;
	logic        switch_on;
	logic [5:0]  led_num;
	logic [31:0] clk_rate;
	logic [31:0] leds;
	logic [31:0] dbg_reg;
	logic [31:0] misc_reg;
	logic [31:0] reload_val;
	logic [31:0] ps_count;
	logic [31:0] evt_count;
	logic [31:0] sec_count;
	logic [32:0] sec_phase;
	logic [31:0] hun_count;
	logic [32:0] hun_phase;

	bcio_pkg::req_t pending_reqs [$];
	bcio_pkg::rsp_t expected_rsps [$];

	int error_count = 0;
	int rsp_seen = 0;
	int cycle_count = 0;
	int mon_cycles = 0;
	int gap_left = 0;
	int burst_left = 0;
	int hold_off_left = 0;
	int hold_off_asks = 0;
	int hold_off_served = 0;

	always #4 clk = ~clk;

	function automatic bcio_pkg::rsp_t predict_board_response(bcio_pkg::req_t r);
		bcio_pkg::rsp_t o;
		logic [32:0] ticks_per_sec;
		int unsigned n;
		logic [31:0] mask;
		o = '0;
		ticks_per_sec = (clk_rate < bcio_pkg::CLK_MIN) ? {1'b0, bcio_pkg::CLK_MIN} :
			{1'b0, clk_rate};
		n = (led_num > 6'd32) ? 32 : led_num;
		mask = (n >= 32) ? 32'hFFFF_FFFF : ((32'h1 << n) - 32'h1);
		case (r.req_type)
		bcio_pkg::REQ_READ: begin
			case (r.reg_offset)
			bcio_pkg::OFS_LED: o.read_data = leds;
			bcio_pkg::OFS_DBGCTRL: begin
				if (dbg_on) o.read_data = dbg_reg;
				else o.ofs_err = 1'b1;
			end
			bcio_pkg::OFS_BUTTON: o.read_data = '0;
			bcio_pkg::OFS_CLK1HZ: o.read_data = sec_count;
			bcio_pkg::OFS_CLK100HZ: o.read_data = hun_count;
			bcio_pkg::OFS_COUNTER: o.read_data = evt_count;
			bcio_pkg::OFS_PRESCALE: o.read_data = reload_val;
			bcio_pkg::OFS_PSCNTR: o.read_data = ps_count;
			bcio_pkg::OFS_SWITCH: o.ofs_err = !switch_on;
			bcio_pkg::OFS_MISC: o.read_data = misc_reg;
			default: o.ofs_err = 1'b1;
			endcase
		end
		bcio_pkg::REQ_WRITE: begin
			case (r.reg_offset)
			bcio_pkg::OFS_LED: begin
				if (led_num != 6'd0) leds = r.write_data & mask;
			end
			bcio_pkg::OFS_DBGCTRL: begin
				if (dbg_on) dbg_reg = r.write_data;
				else o.ofs_err = 1'b1;
			end
			bcio_pkg::OFS_CLK1HZ: begin
				sec_count = r.write_data;
				sec_phase = '0;
			end
			bcio_pkg::OFS_CLK100HZ: begin
				hun_count = r.write_data;
				hun_phase = '0;
			end
			bcio_pkg::OFS_COUNTER: evt_count = r.write_data;
			bcio_pkg::OFS_PRESCALE: reload_val = r.write_data;
			bcio_pkg::OFS_PSCNTR: ps_count = r.write_data;
			bcio_pkg::OFS_MISC: misc_reg = r.write_data;
			default: o.ofs_err = 1'b1;
			endcase
		end
		bcio_pkg::REQ_TICK: begin
			if (ps_count == 32'd0) begin
				ps_count = reload_val;
				evt_count = evt_count + 32'd1;
			end else begin
				ps_count = ps_count - 32'd1;
			end
			sec_phase = sec_phase + bcio_pkg::SEC_STEP;
			if (sec_phase >= ticks_per_sec) begin
				sec_phase = sec_phase - ticks_per_sec;
				sec_count = sec_count + 32'd1;
			end
			hun_phase = hun_phase + bcio_pkg::HUN_STEP;
			if (hun_phase >= ticks_per_sec) begin
				hun_phase = hun_phase - ticks_per_sec;
				hun_count = hun_count + 32'd1;
			end
		end
		default: ;
		endcase
		o.led_drive = leds;
		return o;
	endfunction

	function automatic bcio_pkg::req_t random_request();
		bcio_pkg::req_t r;
		int unsigned pick;
		logic [11:0] ofs;
		pick = $urandom_range(0, 99);
		ofs = REG_OFFSETS[$urandom_range(0, 9)];
		r.req_type = bcio_pkg::REQ_TICK;
		r.reg_offset = 12'($urandom_range(0, 4095));
		r.write_data = $urandom;
		if (pick < 45) begin
			r.req_type = bcio_pkg::REQ_TICK;
		end else if (pick < 70) begin
			r.req_type = bcio_pkg::REQ_READ;
			r.reg_offset = ofs;
		end else if (pick < 90) begin
			r.req_type = bcio_pkg::REQ_WRITE;
			r.reg_offset = ofs;
			if ((ofs == bcio_pkg::OFS_PRESCALE || ofs == bcio_pkg::OFS_PSCNTR) &&
				$urandom_range(0, 3) != 0)
				r.write_data = $urandom_range(0, 4);
			else if (ofs == bcio_pkg::OFS_COUNTER && $urandom_range(0, 1) == 0)
				r.write_data = 32'hFFFF_FFFF - $urandom_range(0, 3);
		end else if (pick < 96) begin
			r.req_type = ($urandom_range(0, 1) == 0) ? bcio_pkg::REQ_READ : bcio_pkg::REQ_WRITE;
		end else begin
			r.req_type = bcio_pkg::REQ_NOP;
		end
		return r;
	endfunction

	task automatic add_req(input bcio_pkg::req_kind_t kind, input logic [11:0] ofs,
		input logic [31:0] data);
		bcio_pkg::req_t r;
		r.req_type = kind;
		r.reg_offset = ofs;
		r.write_data = data;
		pending_reqs.push_back(r);
	endtask

	task automatic write_setting(input bcio_pkg::cfg_idx_t idx, input logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
		bcio_pkg::CFG_HAS_DBG: dbg_on = val[0];
		bcio_pkg::CFG_HAS_SWITCH: switch_on = val[0];
		bcio_pkg::CFG_LED_COUNT: led_num = val[5:0];
		bcio_pkg::CFG_CLOCK_HZ: clk_rate = val;
		default: ;
		endcase
	endtask

	task automatic wait_drained();
		while (pending_reqs.size() != 0 || expected_rsps.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_phase(input int n_random, input bit with_hold_off);
		add_req(bcio_pkg::REQ_WRITE, bcio_pkg::OFS_LED, $urandom);
		add_req(bcio_pkg::REQ_READ, bcio_pkg::OFS_LED, '0);
		add_req(bcio_pkg::REQ_READ, bcio_pkg::OFS_DBGCTRL, '0);
		add_req(bcio_pkg::REQ_READ, bcio_pkg::OFS_SWITCH, '0);
		for (int i = 0; i < n_random; i++)
			pending_reqs.push_back(random_request());
		if (with_hold_off)
			hold_off_asks++;
		wait_drained();
	endtask

	task automatic check_response(input bcio_pkg::rsp_t got);
		bcio_pkg::rsp_t want;
		rsp_seen++;
		if (expected_rsps.size() == 0) begin
			error_count++;
			if (error_count <= 10)
				$display("response %0d with nothing expected: read_data %h ofs_err %b led_drive %h",
					rsp_seen, got.read_data, got.ofs_err, got.led_drive);
		end else begin
			want = expected_rsps.pop_front();
			if (got.read_data !== want.read_data || got.ofs_err !== want.ofs_err ||
				got.led_drive !== want.led_drive) begin
				error_count++;
				if (error_count <= 10)
					$display("response %0d: read_data %h/%h ofs_err %b/%b led_drive %h/%h (exp/got)",
						rsp_seen, want.read_data, got.read_data, want.ofs_err,
						got.ofs_err, want.led_drive, got.led_drive);
			end
		end
	endtask

	// Request driver.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready)
				expected_rsps.push_back(predict_board_response(pending_reqs.pop_front()));
			if (!req_ch.valid || req_ch.ready) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					req_ch.valid <= 1'b0;
				end else if (pending_reqs.size() != 0) begin
					req_ch.valid <= 1'b1;
					req_ch.req_type <= pending_reqs[0].req_type;
					req_ch.reg_offset <= pending_reqs[0].reg_offset;
					req_ch.write_data <= pending_reqs[0].write_data;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 16);
						gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Response monitor with its own stall pattern.
	always @(posedge clk) begin : rsp_monitor
		logic take_next;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready)
				check_response(bcio_pkg::rsp_t'({rsp_ch.read_data, rsp_ch.ofs_err,
					rsp_ch.led_drive}));
			mon_cycles <= mon_cycles + 1;
			case ((mon_cycles / 97) % 4)
			0: take_next = 1'b1;
			1: take_next = ($urandom_range(0, 2) != 0);
			2: take_next = STALL_PATTERN[mon_cycles % 16];
			default: take_next = ($urandom_range(0, 3) == 0);
			endcase
			rsp_ch.ready <= take_next && hold_off_left == 0;
		end
	end

	// Long receiver hold-off, counted here.
	always @(posedge clk) begin
		if (hold_off_left != 0) begin
			hold_off_left <= hold_off_left - 1;
		end else if (hold_off_asks != hold_off_served) begin
			hold_off_served <= hold_off_served + 1;
			hold_off_left <= HOLD_OFF_CYCLES;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_board_control_io_with_prescaled_counter_core: done, errors");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = bcio_pkg::CFG_HAS_DBG;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.req_type = bcio_pkg::REQ_NOP;
		req_ch.reg_offset = '0;
		req_ch.write_data = '0;
		rsp_ch.ready = 1'b0;
		dbg_on = 1'b0;
		switch_on = 1'b0;
		led_num = bcio_pkg::LED_COUNT_RESET;
		clk_rate = bcio_pkg::CLK_HZ_RESET;
		leds = '0;
		dbg_reg = '0;
		misc_reg = '0;
		reload_val = '0;
		ps_count = '0;
		evt_count = '0;
		sec_count = '0;
		sec_phase = '0;
		hun_count = '0;
		hun_phase = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset settings.
		add_req(bcio_pkg::REQ_READ, bcio_pkg::OFS_LED, '0);
		add_req(bcio_pkg::REQ_WRITE, bcio_pkg::OFS_LED, 32'hFFFF_FFFF);
		add_req(bcio_pkg::REQ_READ, bcio_pkg::OFS_LED, '0);
		add_req(bcio_pkg::REQ_READ, bcio_pkg::OFS_DBGCTRL, '0);
		add_req(bcio_pkg::REQ_WRITE, bcio_pkg::OFS_DBGCTRL, 32'h1234_5678);
		add_req(bcio_pkg::REQ_READ, bcio_pkg::OFS_BUTTON, '0);
		add_req(bcio_pkg::REQ_WRITE, bcio_pkg::OFS_BUTTON, 32'hFFFF_FFFF);
		add_req(bcio_pkg::REQ_READ, bcio_pkg::OFS_SWITCH, '0);
		add_req(bcio_pkg::REQ_WRITE, bcio_pkg::OFS_SWITCH, 32'hFFFF_FFFF);
		add_req(bcio_pkg::REQ_TICK, '0, '0);
		add_req(bcio_pkg::REQ_TICK, 12'hFFF, 32'hFFFF_FFFF);
		add_req(bcio_pkg::REQ_WRITE, bcio_pkg::OFS_PRESCALE, 32'd2);
		add_req(bcio_pkg::REQ_TICK, '0, '0);
		add_req(bcio_pkg::REQ_TICK, '0, '0);
		add_req(bcio_pkg::REQ_READ, bcio_pkg::OFS_PSCNTR, '0);
		add_req(bcio_pkg::REQ_WRITE, bcio_pkg::OFS_COUNTER, 32'hFFFF_FFFF);
		add_req(bcio_pkg::REQ_WRITE, bcio_pkg::OFS_PSCNTR, 32'd0);
		add_req(bcio_pkg::REQ_TICK, '0, '0);
		add_req(bcio_pkg::REQ_READ, bcio_pkg::OFS_COUNTER, '0);
		add_req(bcio_pkg::REQ_WRITE, bcio_pkg::OFS_CLK1HZ, 32'hFFFF_FFFF);
		add_req(bcio_pkg::REQ_WRITE, bcio_pkg::OFS_CLK100HZ, 32'h8000_0001);
		add_req(bcio_pkg::REQ_READ, bcio_pkg::OFS_CLK100HZ, '0);
		add_req(bcio_pkg::REQ_WRITE, bcio_pkg::OFS_MISC, 32'hA5A5_5A5A);
		add_req(bcio_pkg::REQ_READ, bcio_pkg::OFS_MISC, '0);
		add_req(bcio_pkg::REQ_READ, 12'hFFF, '0);
		add_req(bcio_pkg::REQ_WRITE, 12'hFFF, 32'hFFFF_FFFF);
		add_req(bcio_pkg::REQ_NOP, bcio_pkg::OFS_LED, 32'hFFFF_FFFF);
		wait_drained();

		write_setting(bcio_pkg::CFG_HAS_DBG, 32'd1);
		write_setting(bcio_pkg::CFG_HAS_SWITCH, 32'd1);
		write_setting(bcio_pkg::CFG_LED_COUNT, 32'd32);
		write_setting(bcio_pkg::CFG_CLOCK_HZ, 32'd100);
		// A long run of ticks so the slow counters roll over at the lowest rate.
		for (int i = 0; i < 100; i++)
			add_req(bcio_pkg::REQ_TICK, 12'($urandom_range(0, 4095)), $urandom);
		add_req(bcio_pkg::REQ_READ, bcio_pkg::OFS_CLK1HZ, '0);
		run_phase(70, 1'b0);

		write_setting(bcio_pkg::CFG_HAS_DBG, 32'd0);
		write_setting(bcio_pkg::CFG_LED_COUNT, 32'd0);
		write_setting(bcio_pkg::CFG_CLOCK_HZ, 32'd0);
		run_phase(70, 1'b0);

		write_setting(bcio_pkg::CFG_HAS_DBG, 32'd1);
		write_setting(bcio_pkg::CFG_HAS_SWITCH, 32'd0);
		write_setting(bcio_pkg::CFG_LED_COUNT, 32'd63);
		write_setting(bcio_pkg::CFG_CLOCK_HZ, 32'd99);
		run_phase(70, 1'b1);

		write_setting(bcio_pkg::CFG_HAS_DBG, 32'd0);
		write_setting(bcio_pkg::CFG_LED_COUNT, 32'd1);
		write_setting(bcio_pkg::CFG_CLOCK_HZ, 32'hFFFF_FFFF);
		run_phase(70, 1'b0);

		write_setting(bcio_pkg::CFG_HAS_DBG, 32'd1);
		write_setting(bcio_pkg::CFG_HAS_SWITCH, 32'd1);
		write_setting(bcio_pkg::CFG_LED_COUNT, 32'd31);
		write_setting(bcio_pkg::CFG_CLOCK_HZ, 32'd137);
		run_phase(70, 1'b0);

		repeat (8) @(posedge clk);
		if (error_count == 0 && expected_rsps.size() == 0)
			$display("tb_board_control_io_with_prescaled_counter_core: done, clean");
		else
			$display("tb_board_control_io_with_prescaled_counter_core: done, errors");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/bcio_pkg.sv
rtl/bcio_ifs.sv
rtl/bcio_slowcnt.sv
rtl/bcio_core.sv
rtl/board_control_io_with_prescaled_counter_core.sv
tb/tb_board_control_io_with_prescaled_counter_core.sv
